// ----- sv/afu_pkg.sv -----
// Package for the audio feature-unit control responder.
// Holds the request and result word types and the protocol constants.
// No dependencies.
package afu_pkg;

    // Request kinds after setup-packet decode
    localparam logic [1:0] KIND_IN  = 2'd0;
    localparam logic [1:0] KIND_OUT = 2'd1;

    // bRequest codes
    localparam logic [7:0] RQ_SET_CUR = 8'h01;
    localparam logic [7:0] RQ_GET_CUR = 8'h81;
    localparam logic [7:0] RQ_GET_MIN = 8'h82;
    localparam logic [7:0] RQ_GET_MAX = 8'h83;
    localparam logic [7:0] RQ_GET_RES = 8'h84;

    // Control selectors
    localparam logic [7:0] SEL_MUTE   = 8'h01;
    localparam logic [7:0] SEL_VOLUME = 8'h02;

    // Channel numbers
    localparam logic [7:0] CHAN_LEFT  = 8'h01;
    localparam logic [7:0] CHAN_RIGHT = 8'h02;

    // Feature-unit entities (wIndex)
    localparam logic [15:0] ENT_PLAY = 16'h0200;
    localparam logic [15:0] ENT_CAPT = 16'h0500;

    // Volume range answers in 1/256 dB
    localparam logic [15:0] VOL_MIN = 16'h8001;
    localparam logic [15:0] VOL_MAX = 16'h0800;
    localparam logic [15:0] VOL_RES = 16'h0088;

    // Gain level after reset (0 dB)
    localparam logic [7:0] GAIN_RESET = 8'd240;

    // Response lengths
    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_BYTE = 2'd1;
    localparam logic [1:0] LEN_WORD = 2'd2;

    // Offset of the dB code
    localparam logic [15:0] DB_OFFSET = 16'h8000;

    // Request word
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  request_code;
        logic [15:0] control_value;
        logic [15:0] entity_index;
        logic [15:0] data_word;
    } t_req;

    // Result word
    typedef struct packed {
        logic        stalled;
        logic [1:0]  response_length;
        logic [15:0] response_data;
        logic        play_mute;
        logic [7:0]  play_gain_left;
        logic [7:0]  play_gain_right;
        logic        capture_mute;
        logic [7:0]  capture_gain;
    } t_rsp;

endpackage

// ----- sv/audio_feature_unit_controls.sv -----
// Top level of the audio feature-unit control responder.
// Depends on afu_pkg, afu_lvl_to_db and afu_db_to_lvl.
//
// Usage:
//   The input channel carries one decoded class control request per word
//   (i_in_valid / o_in_stall / i_in_req). The output channel returns one
//   result word per request (o_out_valid / i_out_stall / o_out_rsp): stall
//   flag, up to two response bytes, and the mute and gain state after the
//   request, which also drives the audio path.
//   A request is captured in an input register, where decode and gain
//   conversion work on it; its result is registered in the output register
//   once that register is free.
//   Throughput is one request per cycle while the receiver does not stall;
//   the state update and the result register advance together, so the next
//   request sees the new state. When the receiver stalls, the result holds;
//   the input register still takes one more word, then o_in_stall rises
//   until the result moves. Reset (synchronous, active low) empties both
//   registers, clears both mute bits and sets all gain levels to 240 (0 dB).
module audio_feature_unit_controls (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  afu_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output afu_pkg::t_rsp o_out_rsp
);

    // Pipeline registers
    logic          r_in_vld;
    afu_pkg::t_req r_in;
    logic          r_out_vld;
    afu_pkg::t_rsp r_out;

    // Control state
    logic       r_play_mute, n_play_mute;
    logic [7:0] r_play_gain_l, n_play_gain_l;
    logic [7:0] r_play_gain_r, n_play_gain_r;
    logic       r_capt_mute, n_capt_mute;
    logic [7:0] r_capt_gain, n_capt_gain;

    logic          out_free;
    logic          adv;
    logic          in_acc;
    afu_pkg::t_rsp n_out;

    logic       is_play;
    logic       is_capt;
    logic [7:0] sel;
    logic [7:0] chan;
    logic       chan_ok;
    logic       chan_right;
    logic [7:0] rd_level;
    logic [15:0] rd_db;
    logic [7:0] wr_level;

    // Handshake: output register frees when empty or taken
    assign out_free   = !r_out_vld || !i_out_stall;
    assign adv        = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Field decode
    assign is_play    = (r_in.entity_index == afu_pkg::ENT_PLAY);
    assign is_capt    = (r_in.entity_index == afu_pkg::ENT_CAPT);
    assign sel        = r_in.control_value[15:8];
    assign chan       = r_in.control_value[7:0];
    assign chan_ok    = (chan == afu_pkg::CHAN_LEFT) || (chan == afu_pkg::CHAN_RIGHT);
    assign chan_right = (chan == afu_pkg::CHAN_RIGHT);

    // Select the level to report
    assign rd_level = !is_play  ? r_capt_gain :
                      chan_right ? r_play_gain_r : r_play_gain_l;

    afu_lvl_to_db u_lvl_to_db (
        .i_level (rd_level),
        .o_db    (rd_db)
    );

    afu_db_to_lvl u_db_to_lvl (
        .i_db    (r_in.data_word),
        .o_level (wr_level)
    );

    // Execute the request against the current state
    always_comb begin
        n_play_mute   = r_play_mute;
        n_play_gain_l = r_play_gain_l;
        n_play_gain_r = r_play_gain_r;
        n_capt_mute   = r_capt_mute;
        n_capt_gain   = r_capt_gain;
        n_out         = '0;
        n_out.stalled = 1'b1;

        if (r_in.kind == afu_pkg::KIND_IN && (is_play || is_capt)) begin
            if (sel == afu_pkg::SEL_MUTE && r_in.request_code == afu_pkg::RQ_GET_CUR) begin
                n_out.stalled         = 1'b0;
                n_out.response_length = afu_pkg::LEN_BYTE;
                n_out.response_data   = {15'd0, is_play ? r_play_mute : r_capt_mute};
            end else if (sel == afu_pkg::SEL_VOLUME && chan_ok) begin
                n_out.stalled         = 1'b0;
                n_out.response_length = afu_pkg::LEN_WORD;
                case (r_in.request_code)
                    afu_pkg::RQ_GET_CUR: n_out.response_data = rd_db;
                    afu_pkg::RQ_GET_MIN: n_out.response_data = afu_pkg::VOL_MIN;
                    afu_pkg::RQ_GET_MAX: n_out.response_data = afu_pkg::VOL_MAX;
                    afu_pkg::RQ_GET_RES: n_out.response_data = afu_pkg::VOL_RES;
                    default: begin
                        n_out.stalled         = 1'b1;
                        n_out.response_length = afu_pkg::LEN_NONE;
                    end
                endcase
            end
        end else if (r_in.kind == afu_pkg::KIND_OUT &&
                     r_in.request_code == afu_pkg::RQ_SET_CUR && (is_play || is_capt)) begin
            if (sel == afu_pkg::SEL_MUTE) begin
                n_out.stalled = 1'b0;
                if (is_play) begin
                    n_play_mute = r_in.data_word[0];
                end else begin
                    n_capt_mute = r_in.data_word[0];
                end
            end else if (sel == afu_pkg::SEL_VOLUME && chan_ok) begin
                n_out.stalled = 1'b0;
                if (!is_play) begin
                    n_capt_gain = wr_level;
                end else if (chan_right) begin
                    n_play_gain_r = wr_level;
                end else begin
                    n_play_gain_l = wr_level;
                end
            end
        end

        n_out.play_mute       = n_play_mute;
        n_out.play_gain_left  = n_play_gain_l;
        n_out.play_gain_right = n_play_gain_r;
        n_out.capture_mute    = n_capt_mute;
        n_out.capture_gain    = n_capt_gain;
    end

    // Hold state and pipeline registers; advance on a free output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_play_mute   <= 1'b0;
            r_play_gain_l <= afu_pkg::GAIN_RESET;
            r_play_gain_r <= afu_pkg::GAIN_RESET;
            r_capt_mute   <= 1'b0;
            r_capt_gain   <= afu_pkg::GAIN_RESET;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (adv) begin
                r_play_mute   <= n_play_mute;
                r_play_gain_l <= n_play_gain_l;
                r_play_gain_r <= n_play_gain_r;
                r_capt_mute   <= n_capt_mute;
                r_capt_gain   <= n_capt_gain;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_req;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out;

    // Checks
    a_reset_empty : assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_stall_no_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.stalled |->
            o_out_rsp.response_length == afu_pkg::LEN_NONE && o_out_rsp.response_data == 16'd0)
        else $error("stalled result carries response bytes");

    a_in_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_vld && r_out_vld)
        else $error("input stalled while a register is empty");

    a_gain_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_play_gain_l) && $stable(r_play_gain_r) && $stable(r_capt_gain))
        else $error("gain changed without a request advancing");

endmodule

// ----- sv/afu_lvl_to_db.sv -----
// Gain level to dB code conversion: (level*0x8800 + 127)/255 + 0x8000.
// Divide by 255 is done as a reciprocal multiply. Uses afu_pkg.
module afu_lvl_to_db (
    input  logic [7:0]  i_level,
    output logic [15:0] o_db
);

    // ceil(2^32 / 255); exact for every dividend below 2^24
    localparam logic [24:0] RECIP_255 = 25'd16843010;

    logic [23:0] x;
    logic [48:0] prod;
    logic [16:0] quot;

    // Scale by 0x8800 (2^15 + 2^11) and round
    assign x    = (24'(i_level) << 15) + (24'(i_level) << 11) + 24'd127;
    assign prod = 49'(x) * 49'(RECIP_255);
    assign quot = prod[48:32];
    assign o_db = quot[15:0] + afu_pkg::DB_OFFSET;

endmodule

// ----- sv/afu_db_to_lvl.sv -----
// dB code to gain level conversion:
// min(255, (((v - 0x8000) mod 2^16)*255 + 0x4400) / 0x8800). Uses afu_pkg.
module afu_db_to_lvl (
    input  logic [15:0] i_db,
    output logic [7:0]  o_level
);

    // ceil(2^17 / 17); exact for every dividend below 8738
    localparam logic [12:0] RECIP_17 = 13'd7711;

    logic [15:0] d;
    logic [23:0] y;
    logic [12:0] w;
    logic [25:0] prod;
    logic [8:0]  quot;

    // Remove offset, scale by 255, add half of 0x8800
    assign d = i_db - afu_pkg::DB_OFFSET;
    assign y = (24'(d) << 8) - 24'(d) + 24'h004400;

    // 0x8800 = 2^11 * 17: shift, then divide by 17
    assign w    = y[23:11];
    assign prod = 26'(w) * 26'(RECIP_17);
    assign quot = prod[25:17];

    // Saturate to the 8-bit level range
    assign o_level = (quot > 9'd255) ? 8'd255 : quot[7:0];

endmodule

// ----- verif/audio_feature_unit_controls_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for audio_feature_unit_controls: random and directed
// control requests checked against a local model of the mute and gain state.
// Depends on afu_pkg and the audio_feature_unit_controls RTL.
module audio_feature_unit_controls_tb;

    // Request codes and kinds the block must refuse
    localparam logic [1:0] KIND_STANDARD = 2'd2;
    localparam logic [1:0] KIND_VENDOR   = 2'd3;
    localparam logic [7:0] RQ_SET_MIN    = 8'h02;
    localparam logic [7:0] RQ_SET_RES    = 8'h04;
    localparam logic [7:0] RQ_GET_MEM    = 8'h85;
    localparam logic [7:0] SEL_BASS      = 8'h03;

    // Level to 1/256 dB scaling
    localparam bit [31:0] DB_SPAN      = 32'h8800;
    localparam bit [31:0] DB_HALF_SPAN = 32'h4400;
    localparam bit [31:0] LEVEL_MAX    = 32'd255;
    localparam bit [31:0] LEVEL_ROUND  = 32'd127;

    // Model of the two feature units plus the replies still owed by the block
    class afu_control_scoreboard;
        afu_pkg::t_rsp owed_replies[$];
        logic       play_mute;
        logic [7:0] play_gain[2];
        logic       capt_mute;
        logic [7:0] capt_gain;
        int         errors;

        function new();
            play_mute    = 1'b0;
            play_gain[0] = afu_pkg::GAIN_RESET;
            play_gain[1] = afu_pkg::GAIN_RESET;
            capt_mute    = 1'b0;
            capt_gain    = afu_pkg::GAIN_RESET;
            errors       = 0;
        endfunction

        function int pending();
            return owed_replies.size();
        endfunction

        function logic [15:0] level_to_db256(logic [7:0] lv);
            bit [31:0] t;
            t = ({24'd0, lv} * DB_SPAN + LEVEL_ROUND) / LEVEL_MAX
                + {16'd0, afu_pkg::DB_OFFSET};
            return t[15:0];
        endfunction

        function logic [7:0] db256_to_level(logic [15:0] v);
            bit [15:0] d;
            bit [31:0] q;
            d = v - afu_pkg::DB_OFFSET;
            q = ({16'd0, d} * LEVEL_MAX + DB_HALF_SPAN) / DB_SPAN;
            return (q > LEVEL_MAX) ? 8'hFF : q[7:0];
        endfunction

        // Apply one request to the model and queue the reply it causes
        function void note_request(afu_pkg::t_req r);
            afu_pkg::t_rsp y;
            logic [7:0] sel;
            logic [7:0] chan_idx;
            logic       chan_ok;
            logic       play;
            logic       capt;
            y         = '0;
            y.stalled = 1'b1;
            sel       = r.control_value[15:8];
            chan_idx  = r.control_value[7:0] - 8'd1;
            chan_ok   = chan_idx < 8'd2;
            play      = r.entity_index == afu_pkg::ENT_PLAY;
            capt      = r.entity_index == afu_pkg::ENT_CAPT;
            if (r.kind == afu_pkg::KIND_IN && (play || capt)) begin
                if (sel == afu_pkg::SEL_MUTE && r.request_code == afu_pkg::RQ_GET_CUR) begin
                    y.stalled         = 1'b0;
                    y.response_length = afu_pkg::LEN_BYTE;
                    y.response_data   = {15'd0, play ? play_mute : capt_mute};
                end else if (sel == afu_pkg::SEL_VOLUME && chan_ok) begin
                    y.stalled         = 1'b0;
                    y.response_length = afu_pkg::LEN_WORD;
                    case (r.request_code)
                        afu_pkg::RQ_GET_CUR: begin
                            y.response_data = level_to_db256(play ? play_gain[chan_idx[0]]
                                                                  : capt_gain);
                        end
                        afu_pkg::RQ_GET_MIN: y.response_data = afu_pkg::VOL_MIN;
                        afu_pkg::RQ_GET_MAX: y.response_data = afu_pkg::VOL_MAX;
                        afu_pkg::RQ_GET_RES: y.response_data = afu_pkg::VOL_RES;
                        default: begin
                            y.stalled         = 1'b1;
                            y.response_length = afu_pkg::LEN_NONE;
                        end
                    endcase
                end
            end else if (r.kind == afu_pkg::KIND_OUT && r.request_code == afu_pkg::RQ_SET_CUR
                         && (play || capt)) begin
                if (sel == afu_pkg::SEL_MUTE) begin
                    if (play) play_mute = r.data_word[0];
                    else capt_mute = r.data_word[0];
                    y.stalled = 1'b0;
                end else if (sel == afu_pkg::SEL_VOLUME && chan_ok) begin
                    if (play) play_gain[chan_idx[0]] = db256_to_level(r.data_word);
                    else capt_gain = db256_to_level(r.data_word);
                    y.stalled = 1'b0;
                end
            end
            y.play_mute       = play_mute;
            y.play_gain_left  = play_gain[0];
            y.play_gain_right = play_gain[1];
            y.capture_mute    = capt_mute;
            y.capture_gain    = capt_gain;
            owed_replies.push_back(y);
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", name, got, want));
        endtask

        // Compare one result word with the oldest owed reply
        task check_reply(afu_pkg::t_rsp got);
            afu_pkg::t_rsp want;
            if (owed_replies.size() == 0) begin
                report("result word with no request waiting");
                return;
            end
            want = owed_replies.pop_front();
            compare_field("stalled", 16'(got.stalled), 16'(want.stalled));
            compare_field("response_length", 16'(got.response_length),
                          16'(want.response_length));
            compare_field("response_data", got.response_data, want.response_data);
            compare_field("play_mute", 16'(got.play_mute), 16'(want.play_mute));
            compare_field("play_gain_left", 16'(got.play_gain_left),
                          16'(want.play_gain_left));
            compare_field("play_gain_right", 16'(got.play_gain_right),
                          16'(want.play_gain_right));
            compare_field("capture_mute", 16'(got.capture_mute), 16'(want.capture_mute));
            compare_field("capture_gain", 16'(got.capture_gain), 16'(want.capture_gain));
        endtask
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_stall = 1'b0;
    afu_pkg::t_req i_in_req = '0;
    logic o_in_stall;
    logic o_out_valid;
    afu_pkg::t_rsp o_out_rsp;

    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    afu_control_scoreboard sb = new();

    audio_feature_unit_controls dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    always #2 i_clk = ~i_clk;

    // Check each accepted result word, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_reply(o_out_rsp);
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    function automatic afu_pkg::t_req compose_request(logic [1:0] kind, logic [7:0] code,
                                                      logic [7:0] sel, logic [7:0] chan,
                                                      logic [15:0] ent, logic [15:0] data);
        afu_pkg::t_req r;
        r.kind          = kind;
        r.request_code  = code;
        r.control_value = {sel, chan};
        r.entity_index  = ent;
        r.data_word     = data;
        return r;
    endfunction

    // Mostly well-formed requests with random content, some noise
    function automatic afu_pkg::t_req make_request();
        afu_pkg::t_req r;
        logic [7:0] sel;
        logic [7:0] chan;
        logic [7:0] code;
        logic [15:0] ent;
        logic [15:0] data;
        logic [1:0]  kind;
        if ($urandom_range(0, 99) < 12) begin
            r = afu_pkg::t_req'({$urandom(), 26'($urandom())});
            return r;
        end
        kind = ($urandom_range(0, 9) < 4) ? afu_pkg::KIND_OUT : afu_pkg::KIND_IN;
        case ($urandom_range(0, 9))
            0, 1, 2:                sel = afu_pkg::SEL_MUTE;
            9:                      sel = 8'($urandom);
            default:                sel = afu_pkg::SEL_VOLUME;
        endcase
        case ($urandom_range(0, 9))
            0:       chan = 8'($urandom);
            1:       chan = 8'd0;
            2:       chan = 8'd3;
            default: chan = $urandom_range(0, 1) ? afu_pkg::CHAN_RIGHT : afu_pkg::CHAN_LEFT;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: ent = afu_pkg::ENT_PLAY;
            9:             ent = afu_pkg::ENT_PLAY ^ (16'd1 << $urandom_range(0, 15));
            default:       ent = afu_pkg::ENT_CAPT;
        endcase
        if (kind == afu_pkg::KIND_IN) begin
            case ($urandom_range(0, 9))
                4:       code = afu_pkg::RQ_GET_MIN;
                5:       code = afu_pkg::RQ_GET_MAX;
                6:       code = afu_pkg::RQ_GET_RES;
                8:       code = afu_pkg::RQ_SET_CUR;
                9:       code = 8'($urandom);
                default: code = afu_pkg::RQ_GET_CUR;
            endcase
        end else begin
            case ($urandom_range(0, 9))
                8:       code = $urandom_range(0, 1) ? RQ_SET_MIN : RQ_SET_RES;
                9:       code = 8'($urandom);
                default: code = afu_pkg::RQ_SET_CUR;
            endcase
        end
        case ($urandom_range(0, 4))
            0:       data = 16'($urandom);
            1:       data = afu_pkg::DB_OFFSET + 16'($urandom_range(0, 255)) * afu_pkg::VOL_RES;
            2:       data = afu_pkg::DB_OFFSET + 16'($urandom_range(0, 3));
            3:       data = 16'($urandom_range(0, 16'h0900));
            default: data = 16'($urandom_range(16'h8000, 16'hFFFF));
        endcase
        return compose_request(kind, code, sel, chan, ent, data);
    endfunction

    // Offer one word, hold it until accepted, then record it
    task send_request(input afu_pkg::t_req r);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(r);
    endtask

    // Hold off the sender until every owed reply has come back
    task drain_replies();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        #2_000_000;
        $display("audio_feature_unit_controls_tb: errors");
        $finish;
    end

    initial begin
        afu_pkg::t_req directed[$];
        int   idle_plan[4];
        int   stall_plan[4];
        idle_plan  = '{0, 70, 0, 32};
        stall_plan = '{0, 0, 70, 32};

        // Reads at reset, range constants, sets at the extremes, read back
        directed.push_back(compose_request(afu_pkg::KIND_IN, afu_pkg::RQ_GET_CUR,
                                           afu_pkg::SEL_MUTE, 8'd0,
                                           afu_pkg::ENT_PLAY, 16'hFFFF));
        directed.push_back(compose_request(afu_pkg::KIND_IN, afu_pkg::RQ_GET_CUR,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_LEFT,
                                           afu_pkg::ENT_PLAY, 16'h0000));
        directed.push_back(compose_request(afu_pkg::KIND_IN, afu_pkg::RQ_GET_MIN,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_LEFT,
                                           afu_pkg::ENT_PLAY, 16'h0000));
        directed.push_back(compose_request(afu_pkg::KIND_IN, afu_pkg::RQ_GET_MAX,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_RIGHT,
                                           afu_pkg::ENT_CAPT, 16'h0000));
        directed.push_back(compose_request(afu_pkg::KIND_IN, afu_pkg::RQ_GET_RES,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_RIGHT,
                                           afu_pkg::ENT_PLAY, 16'h0000));
        directed.push_back(compose_request(afu_pkg::KIND_OUT, afu_pkg::RQ_SET_CUR,
                                           afu_pkg::SEL_MUTE, 8'hFF,
                                           afu_pkg::ENT_PLAY, 16'hFFFF));
        directed.push_back(compose_request(afu_pkg::KIND_OUT, afu_pkg::RQ_SET_CUR,
                                           afu_pkg::SEL_MUTE, afu_pkg::CHAN_LEFT,
                                           afu_pkg::ENT_CAPT, 16'h0001));
        directed.push_back(compose_request(afu_pkg::KIND_OUT, afu_pkg::RQ_SET_CUR,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_LEFT,
                                           afu_pkg::ENT_PLAY, afu_pkg::DB_OFFSET));
        directed.push_back(compose_request(afu_pkg::KIND_OUT, afu_pkg::RQ_SET_CUR,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_RIGHT,
                                           afu_pkg::ENT_PLAY, 16'h7FFF));
        directed.push_back(compose_request(afu_pkg::KIND_OUT, afu_pkg::RQ_SET_CUR,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_LEFT,
                                           afu_pkg::ENT_CAPT, afu_pkg::VOL_MAX));
        directed.push_back(compose_request(afu_pkg::KIND_IN, afu_pkg::RQ_GET_CUR,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_LEFT,
                                           afu_pkg::ENT_PLAY, 16'h0000));
        directed.push_back(compose_request(afu_pkg::KIND_IN, afu_pkg::RQ_GET_CUR,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_RIGHT,
                                           afu_pkg::ENT_PLAY, 16'h0000));
        directed.push_back(compose_request(afu_pkg::KIND_IN, afu_pkg::RQ_GET_CUR,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_RIGHT,
                                           afu_pkg::ENT_CAPT, 16'h0000));
        directed.push_back(compose_request(afu_pkg::KIND_IN, afu_pkg::RQ_GET_CUR,
                                           afu_pkg::SEL_MUTE, afu_pkg::CHAN_RIGHT,
                                           afu_pkg::ENT_CAPT, 16'h0000));
        directed.push_back(compose_request(afu_pkg::KIND_OUT, afu_pkg::RQ_SET_CUR,
                                           afu_pkg::SEL_MUTE, afu_pkg::CHAN_LEFT,
                                           afu_pkg::ENT_PLAY, 16'hFFFE));
        // Bad channel on get and set
        directed.push_back(compose_request(afu_pkg::KIND_IN, afu_pkg::RQ_GET_CUR,
                                           afu_pkg::SEL_VOLUME, 8'd0,
                                           afu_pkg::ENT_PLAY, 16'h0000));
        directed.push_back(compose_request(afu_pkg::KIND_OUT, afu_pkg::RQ_SET_CUR,
                                           afu_pkg::SEL_VOLUME, 8'd3,
                                           afu_pkg::ENT_CAPT, 16'h8000));
        // Unknown selector, entity and code
        directed.push_back(compose_request(afu_pkg::KIND_IN, afu_pkg::RQ_GET_CUR,
                                           SEL_BASS, afu_pkg::CHAN_LEFT,
                                           afu_pkg::ENT_PLAY, 16'h0000));
        directed.push_back(compose_request(afu_pkg::KIND_IN, afu_pkg::RQ_GET_CUR,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_LEFT,
                                           afu_pkg::ENT_PLAY | 16'h0001, 16'h0000));
        directed.push_back(compose_request(afu_pkg::KIND_IN, RQ_GET_MEM,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_LEFT,
                                           afu_pkg::ENT_PLAY, 16'h0000));
        // Other request kinds
        directed.push_back(compose_request(KIND_STANDARD, afu_pkg::RQ_GET_CUR,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_LEFT,
                                           afu_pkg::ENT_PLAY, 16'h0000));
        directed.push_back(compose_request(KIND_VENDOR, afu_pkg::RQ_SET_CUR,
                                           afu_pkg::SEL_MUTE, afu_pkg::CHAN_LEFT,
                                           afu_pkg::ENT_CAPT, 16'h0000));
        // Set of a range attribute, and a set code sent as IN
        directed.push_back(compose_request(afu_pkg::KIND_OUT, RQ_SET_MIN,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_LEFT,
                                           afu_pkg::ENT_PLAY, 16'h8000));
        directed.push_back(compose_request(afu_pkg::KIND_IN, afu_pkg::RQ_SET_CUR,
                                           afu_pkg::SEL_VOLUME, afu_pkg::CHAN_LEFT,
                                           afu_pkg::ENT_CAPT, 16'h8000));
        // All-zero and all-ones words
        directed.push_back(afu_pkg::t_req'('0));
        directed.push_back(afu_pkg::t_req'('1));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_request(directed[i]);
        drain_replies();

        // Random phases under different idle and stall pressure
        for (int p = 0; p < 4; p++) begin
            in_idle_pct   = idle_plan[p];
            out_stall_pct = stall_plan[p];
            repeat (320) send_request(make_request());
            drain_replies();
        end

        out_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("audio_feature_unit_controls_tb: clean");
        end else begin
            $display("audio_feature_unit_controls_tb: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/afu_pkg.sv
sv/afu_lvl_to_db.sv
sv/afu_db_to_lvl.sv
sv/audio_feature_unit_controls.sv
verif/audio_feature_unit_controls_tb.sv
